// ===== src/tpd_pkg.sv =====
// Package for the tone presence detector: shared types, codes and constants.
// Used by tpd_mac, tpd_seq and tone_presence_detector; depends on nothing.
package tpd_pkg;

  localparam int AccW = 66;
  localparam int PcW  = 5;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TAP    = 1'b1;

  localparam logic [2:0] CFG_RES_COEF_A  = 3'd0;
  localparam logic [2:0] CFG_RES_COEF_B  = 3'd1;
  localparam logic [2:0] CFG_RES_COEF_C  = 3'd2;
  localparam logic [2:0] CFG_RATIO_GAIN  = 3'd3;
  localparam logic [2:0] CFG_POWER_FLOOR = 3'd4;

  typedef enum logic [1:0] {
    VERD_LOW     = 2'd0,
    VERD_ABSENT  = 2'd1,
    VERD_PRESENT = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_mode_e;

  typedef enum logic [4:0] {
    SRC_ONE, SRC_K13, SRC_K14, SRC_K15, SRC_POLE, SRC_POLEC,
    SRC_X, SRC_XX, SRC_NEW, SRC_OLD, SRC_W, SRC_Y, SRC_P,
    SRC_TOT, SRC_TOTC, SRC_RES, SRC_CA, SRC_CB, SRC_CC, SRC_GAIN,
    SRC_TAP, SRC_DLY
  } src_e;

  typedef enum logic [2:0] {
    DST_X, DST_XX, DST_W, DST_Y, DST_P, DST_TOT, DST_RES, DST_VERD
  } dst_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIR,
    ST_MICRO,
    ST_WAIT
  } seq_state_e;

  typedef struct packed {
    src_e      src_a;
    src_e      src_b;
    mac_mode_e mode;
    logic      last;
    dst_e      dest;
  } uop_t;

  typedef struct packed {
    logic               valid;
    mac_mode_e          mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mac_op_t;

  typedef struct packed {
    logic      stall;
    logic      rd_en;
    logic      op_v;
    mac_mode_e mode;
    src_e      src_a;
    src_e      src_b;
    logic      cap;
    dst_e      dest;
  } ctrl_t;

  function automatic uop_t uop_rom(input logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = '{SRC_X,    SRC_X,     MAC_LOAD, 1'b1, DST_XX};
      5'd1:    u = '{SRC_K13,  SRC_ONE,   MAC_LOAD, 1'b0, DST_W};
      5'd2:    u = '{SRC_CB,   SRC_NEW,   MAC_ADD,  1'b0, DST_W};
      5'd3:    u = '{SRC_CC,   SRC_OLD,   MAC_ADD,  1'b0, DST_W};
      5'd4:    u = '{SRC_X,    SRC_K14,   MAC_ADD,  1'b1, DST_W};
      5'd5:    u = '{SRC_K13,  SRC_ONE,   MAC_LOAD, 1'b0, DST_Y};
      5'd6:    u = '{SRC_CA,   SRC_NEW,   MAC_ADD,  1'b0, DST_Y};
      5'd7:    u = '{SRC_W,    SRC_K14,   MAC_ADD,  1'b0, DST_Y};
      5'd8:    u = '{SRC_OLD,  SRC_K14,   MAC_ADD,  1'b1, DST_Y};
      5'd9:    u = '{SRC_X,    SRC_X,     MAC_LOAD, 1'b0, DST_P};
      5'd10:   u = '{SRC_Y,    SRC_Y,     MAC_SUB,  1'b1, DST_P};
      5'd11:   u = '{SRC_K14,  SRC_ONE,   MAC_LOAD, 1'b0, DST_TOT};
      5'd12:   u = '{SRC_TOT,  SRC_POLE,  MAC_ADD,  1'b0, DST_TOT};
      5'd13:   u = '{SRC_XX,   SRC_POLEC, MAC_ADD,  1'b1, DST_TOT};
      5'd14:   u = '{SRC_K14,  SRC_ONE,   MAC_LOAD, 1'b0, DST_RES};
      5'd15:   u = '{SRC_RES,  SRC_POLE,  MAC_ADD,  1'b0, DST_RES};
      5'd16:   u = '{SRC_P,    SRC_POLEC, MAC_ADD,  1'b1, DST_RES};
      5'd17:   u = '{SRC_TOTC, SRC_GAIN,  MAC_LOAD, 1'b0, DST_VERD};
      5'd18:   u = '{SRC_RES,  SRC_K15,   MAC_SUB,  1'b1, DST_VERD};
      default: u = '{SRC_ONE,  SRC_ONE,   MAC_LOAD, 1'b1, DST_VERD};
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [31:0] r;
    if (&v[AccW-1:31] || ~|v[AccW-1:31]) begin
      r = v[31:0];
    end else if (v[AccW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
    logic signed [15:0] r;
    if (&v[AccW-1:15] || ~|v[AccW-1:15]) begin
      r = v[15:0];
    end else if (v[AccW-1]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7FFF;
    end
    return r;
  endfunction

endpackage

// ===== src/tpd_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 signed product, then accumulate.
// Depends on tpd_pkg.
module tpd_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpd_pkg::mac_op_t                 op_i,
  output logic signed [tpd_pkg::AccW-1:0]  acc_o,
  output logic                             busy_o
);

  logic signed [31:0]               a_s, b_s;
  logic signed [63:0]               prod_d, prod_q;
  tpd_pkg::mac_mode_e               mode_q;
  logic                             v_q;
  logic signed [tpd_pkg::AccW-1:0]  prod_ext, acc_d, acc_q;

  assign a_s    = op_i.a;
  assign b_s    = op_i.b;
  assign prod_d = 64'(a_s) * 64'(b_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      prod_q <= prod_d;
      mode_q <= op_i.mode;
    end
  end

  assign prod_ext = tpd_pkg::AccW'(prod_q);

  always_comb begin
    case (mode_q)
      tpd_pkg::MAC_LOAD: acc_d = prod_ext;
      tpd_pkg::MAC_ADD:  acc_d = acc_q + prod_ext;
      tpd_pkg::MAC_SUB:  acc_d = acc_q - prod_ext;
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = v_q;

endmodule

// ===== src/tpd_taps.sv =====
// FIR tap store and circular delay line with registered reads and read-address walk.
// Depends on nothing outside this file.
module tpd_taps #(
  parameter int TAPS = 53,
  parameter int IdxW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tap_we_i,
  input  logic [IdxW-1:0]         tap_idx_i,
  input  logic signed [15:0]      tap_val_i,
  input  logic                    smp_we_i,
  input  logic signed [15:0]      smp_val_i,
  input  logic                    rd_en_i,
  output logic signed [15:0]      tap_o,
  output logic signed [15:0]      dly_o,
  output logic                    rd_v_o,
  output logic                    rd_last_o
);

  localparam logic [IdxW:0]   TapsW   = (IdxW+1)'(TAPS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TAPS - 1);

  logic [15:0]      tap_mem [TAPS];
  logic [15:0]      dly_mem [TAPS];
  logic [TAPS-1:0]  dly_vld_q;
  logic [IdxW-1:0]  newest_q, newest_nxt, pos_q, k_q;
  logic [15:0]      tap_rd_q, dly_rd_q;
  logic             dly_rv_q, rd_v_q, tap_ok;

  assign newest_nxt = (newest_q == LastIdx) ? '0 : newest_q + 1'b1;
  assign tap_ok     = tap_we_i && ({1'b0, tap_idx_i} < TapsW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q  <= '0;
      pos_q     <= '0;
      k_q       <= '0;
      dly_vld_q <= '0;
      dly_rv_q  <= 1'b0;
      rd_v_q    <= 1'b0;
    end else begin
      rd_v_q <= rd_en_i;
      if (smp_we_i) begin
        newest_q              <= newest_nxt;
        pos_q                 <= newest_nxt;
        k_q                   <= '0;
        dly_vld_q[newest_nxt] <= 1'b1;
      end else if (rd_en_i) begin
        k_q      <= k_q + 1'b1;
        pos_q    <= (pos_q == '0) ? LastIdx : pos_q - 1'b1;
        dly_rv_q <= dly_vld_q[pos_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_ok) begin
      tap_mem[tap_idx_i] <= tap_val_i;
    end
    if (smp_we_i) begin
      dly_mem[newest_nxt] <= smp_val_i;
    end
    if (rd_en_i) begin
      tap_rd_q <= tap_mem[k_q];
      dly_rd_q <= dly_mem[pos_q];
    end
  end

  assign tap_o     = tap_rd_q;
  assign dly_o     = dly_rv_q ? dly_rd_q : 16'sd0;
  assign rd_v_o    = rd_v_q;
  assign rd_last_o = (k_q == LastIdx);

endmodule

// ===== src/tpd_seq.sv =====
// Sequencer: walks the FIR taps, then the micro-op program through the shared MAC.
// Depends on tpd_pkg.
module tpd_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            rd_v_i,
  input  logic            rd_last_i,
  input  logic            mac_busy_i,
  input  logic            out_free_i,
  input  logic            eob_i,
  output tpd_pkg::ctrl_t  ctrl_o
);

  tpd_pkg::seq_state_e         state_q, state_d;
  logic [tpd_pkg::PcW-1:0]     pc_q, pc_d;
  tpd_pkg::dst_e               dest_q, dest_d;
  tpd_pkg::uop_t               uop;
  logic                        done;

  assign uop  = tpd_pkg::uop_rom(pc_q);
  assign done = !rd_v_i && !mac_busy_i && ((dest_q != tpd_pkg::DST_VERD) || out_free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpd_pkg::ST_IDLE;
      pc_q    <= '0;
      dest_q  <= tpd_pkg::DST_X;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      dest_q  <= dest_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    dest_d  = dest_q;
    case (state_q)
      tpd_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = tpd_pkg::ST_FIR;
        end
      end
      tpd_pkg::ST_FIR: begin
        if (rd_last_i) begin
          state_d = tpd_pkg::ST_WAIT;
          dest_d  = tpd_pkg::DST_X;
          pc_d    = '0;
        end
      end
      tpd_pkg::ST_MICRO: begin
        pc_d = pc_q + 1'b1;
        if (uop.last) begin
          state_d = tpd_pkg::ST_WAIT;
          dest_d  = uop.dest;
        end
      end
      tpd_pkg::ST_WAIT: begin
        if (done) begin
          if ((dest_q == tpd_pkg::DST_VERD) || ((dest_q == tpd_pkg::DST_RES) && !eob_i)) begin
            state_d = tpd_pkg::ST_IDLE;
          end else begin
            state_d = tpd_pkg::ST_MICRO;
          end
        end
      end
      default: state_d = tpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.stall = (state_q != tpd_pkg::ST_IDLE);
    ctrl_o.rd_en = (state_q == tpd_pkg::ST_FIR);
    ctrl_o.cap   = (state_q == tpd_pkg::ST_WAIT) && done;
    ctrl_o.dest  = dest_q;
    ctrl_o.mode  = tpd_pkg::MAC_LOAD;
    ctrl_o.src_a = tpd_pkg::SRC_ONE;
    ctrl_o.src_b = tpd_pkg::SRC_ONE;
    if (rd_v_i) begin
      ctrl_o.op_v  = 1'b1;
      ctrl_o.mode  = tpd_pkg::MAC_ADD;
      ctrl_o.src_a = tpd_pkg::SRC_TAP;
      ctrl_o.src_b = tpd_pkg::SRC_DLY;
    end else if (state_q == tpd_pkg::ST_FIR) begin
      ctrl_o.op_v  = 1'b1;
      ctrl_o.src_a = tpd_pkg::SRC_K14;
    end else if (state_q == tpd_pkg::ST_MICRO) begin
      ctrl_o.op_v  = 1'b1;
      ctrl_o.mode  = uop.mode;
      ctrl_o.src_a = uop.src_a;
      ctrl_o.src_b = uop.src_b;
    end
  end

endmodule

// ===== src/tone_presence_detector.sv =====
// Tone presence detector top level: FIR band-pass, resonator, power averages, verdict.
// A sample holds the input stalled through the FIR walk and the micro-op program,
// longer on a block end, whose verdict becomes valid as the input reopens. No new
// sample or tap write is taken until then; the single shared MAC serves each step.
// Reset: delay line, filter states and averages clear; registers take defaults.
// Depends on tpd_pkg, tpd_mac, tpd_taps and tpd_seq.
module tone_presence_detector #(
  parameter int TAPS = 53,
  parameter int IdxW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [30:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic signed [15:0]  sample_in_i,
  input  logic                end_of_block_i,
  input  logic [IdxW-1:0]     tap_index_i,
  input  logic signed [15:0]  tap_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          verdict_o,
  output logic [30:0]         total_power_o,
  output logic [30:0]         residual_power_o
);

  tpd_pkg::ctrl_t                   ctrl;
  tpd_pkg::mac_op_t                 mac_op;
  logic signed [tpd_pkg::AccW-1:0]  acc;
  logic                             mac_busy, rd_v, rd_last, in_acc, smp_we, tap_we;
  logic                             out_free, eob_q, tot_low;
  logic signed [15:0]               tap_rd, dly_rd;
  logic signed [15:0]               coef_a_q, coef_b_q, coef_c_q, x_q;
  logic [14:0]                      gain_q;
  logic [30:0]                      floor_q;
  logic signed [31:0]               xx_q, w_q, y_q, p_q, new_q, old_q, tot_q, res_q;
  logic signed [31:0]               totc, res_sat;
  logic                             out_valid_q;
  logic [1:0]                       verdict_q;
  logic [30:0]                      total_q, residual_q;

  function automatic logic signed [31:0] operand(input tpd_pkg::src_e s);
    logic signed [31:0] v;
    case (s)
      tpd_pkg::SRC_ONE:   v = 32'sd1;
      tpd_pkg::SRC_K13:   v = 32'sd8192;
      tpd_pkg::SRC_K14:   v = 32'sd16384;
      tpd_pkg::SRC_K15:   v = 32'sd32768;
      tpd_pkg::SRC_POLE:  v = 32'sd31130;
      tpd_pkg::SRC_POLEC: v = 32'sd1638;
      tpd_pkg::SRC_X:     v = 32'(x_q);
      tpd_pkg::SRC_XX:    v = xx_q;
      tpd_pkg::SRC_NEW:   v = new_q;
      tpd_pkg::SRC_OLD:   v = old_q;
      tpd_pkg::SRC_W:     v = w_q;
      tpd_pkg::SRC_Y:     v = y_q;
      tpd_pkg::SRC_P:     v = p_q;
      tpd_pkg::SRC_TOT:   v = tot_q;
      tpd_pkg::SRC_TOTC:  v = totc;
      tpd_pkg::SRC_RES:   v = res_q;
      tpd_pkg::SRC_CA:    v = 32'(coef_a_q);
      tpd_pkg::SRC_CB:    v = 32'(coef_b_q);
      tpd_pkg::SRC_CC:    v = 32'(coef_c_q);
      tpd_pkg::SRC_GAIN:  v = {17'd0, gain_q};
      tpd_pkg::SRC_TAP:   v = 32'(tap_rd);
      tpd_pkg::SRC_DLY:   v = 32'(dly_rd);
      default:            v = 32'sd0;
    endcase
    return v;
  endfunction

  assign in_stall_o  = ctrl.stall;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign smp_we      = in_acc && (req_type_i == tpd_pkg::REQ_SAMPLE);
  assign tap_we      = in_acc && (req_type_i == tpd_pkg::REQ_TAP);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign totc        = tot_q[31] ? 32'sd0 : tot_q;
  assign tot_low     = (totc[30:0] < floor_q);
  assign res_sat     = tpd_pkg::sat32(acc >>> 15);

  always_comb begin
    mac_op.valid = ctrl.op_v;
    mac_op.mode  = ctrl.mode;
    mac_op.a     = operand(ctrl.src_a);
    mac_op.b     = operand(ctrl.src_b);
  end

  tpd_taps #(
    .TAPS (TAPS),
    .IdxW (IdxW)
  ) u_taps (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tap_we_i  (tap_we),
    .tap_idx_i (tap_index_i),
    .tap_val_i (tap_value_i),
    .smp_we_i  (smp_we),
    .smp_val_i (sample_in_i),
    .rd_en_i   (ctrl.rd_en),
    .tap_o     (tap_rd),
    .dly_o     (dly_rd),
    .rd_v_o    (rd_v),
    .rd_last_o (rd_last)
  );

  tpd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  tpd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (smp_we),
    .rd_v_i     (rd_v),
    .rd_last_i  (rd_last),
    .mac_busy_i (mac_busy),
    .out_free_i (out_free),
    .eob_i      (eob_q),
    .ctrl_o     (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= 16'sd2573;
      coef_b_q <= -16'sd2412;
      coef_c_q <= -16'sd14400;
      gain_q   <= 15'd24576;
      floor_q  <= 31'd10737418;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tpd_pkg::CFG_RES_COEF_A:  coef_a_q <= cfg_data_i[15:0];
        tpd_pkg::CFG_RES_COEF_B:  coef_b_q <= cfg_data_i[15:0];
        tpd_pkg::CFG_RES_COEF_C:  coef_c_q <= cfg_data_i[15:0];
        tpd_pkg::CFG_RATIO_GAIN:  gain_q   <= cfg_data_i[14:0];
        tpd_pkg::CFG_POWER_FLOOR: floor_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_q       <= '0;
      old_q       <= '0;
      tot_q       <= '0;
      res_q       <= '0;
      eob_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (smp_we) begin
        eob_q <= end_of_block_i;
      end
      if (ctrl.cap && (ctrl.dest == tpd_pkg::DST_Y)) begin
        old_q <= new_q;
        new_q <= w_q;
      end
      if (ctrl.cap && (ctrl.dest == tpd_pkg::DST_TOT)) begin
        tot_q <= res_sat;
      end
      if (ctrl.cap && (ctrl.dest == tpd_pkg::DST_RES)) begin
        res_q <= (eob_q && res_sat[31]) ? 32'sd0 : res_sat;
      end
      if (ctrl.cap && (ctrl.dest == tpd_pkg::DST_VERD)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.cap) begin
      case (ctrl.dest)
        tpd_pkg::DST_X:  x_q  <= tpd_pkg::sat16(acc >>> 15);
        tpd_pkg::DST_XX: xx_q <= acc[31:0];
        tpd_pkg::DST_W:  w_q  <= tpd_pkg::sat32(acc >>> 14);
        tpd_pkg::DST_Y:  y_q  <= tpd_pkg::sat32(acc >>> 14);
        tpd_pkg::DST_P:  p_q  <= tpd_pkg::sat32(acc);
        tpd_pkg::DST_VERD: begin
          if (tot_low) begin
            verdict_q <= tpd_pkg::VERD_LOW;
          end else if (acc[tpd_pkg::AccW-1]) begin
            verdict_q <= tpd_pkg::VERD_PRESENT;
          end else begin
            verdict_q <= tpd_pkg::VERD_ABSENT;
          end
          total_q    <= totc[30:0];
          residual_q <= res_q[30:0];
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign total_power_o    = total_q;
  assign residual_power_o = residual_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_stall_o |-> !mac_busy)
    else $error("shared MAC busy while input is open");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_v |-> in_stall_o)
    else $error("tap read data arrived outside a sample");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.cap && (ctrl.dest == tpd_pkg::DST_VERD)) |-> !(out_valid_q && out_stall_i))
    else $error("verdict captured over a pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.cap && (ctrl.dest == tpd_pkg::DST_VERD)) |-> eob_q)
    else $error("verdict produced without block end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.cap |-> (!mac_busy && !rd_v))
    else $error("result captured before the MAC drained");

endmodule
